// File: rtl/sawgen_pkg.sv
// sawgen_pkg: shared types and constants of the sawtooth generator with key control
// controller/datapath command and status structs, register indexes, reset values
// no dependencies
package sawgen_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;
	localparam int CFG_REG_W  = 8;
	localparam int KEY_W      = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_AMP_MAX    = 3'd0,
		REG_AMP_STEP   = 3'd1,
		REG_PER_MIN    = 3'd2,
		REG_PER_MAX    = 3'd3,
		REG_PER_STEP   = 3'd4,
		REG_DEB_RELOAD = 3'd5
	} reg_idx_t;

	localparam logic [CFG_DATA_W-1:0] AMP_MAX_RST    = 10'd1023;
	localparam logic [CFG_REG_W-1:0]  AMP_STEP_RST   = 8'd10;
	localparam logic [CFG_REG_W-1:0]  PER_MIN_RST    = 8'd1;
	localparam logic [CFG_REG_W-1:0]  PER_MAX_RST    = 8'd200;
	localparam logic [CFG_REG_W-1:0]  PER_STEP_RST   = 8'd10;
	localparam logic [CFG_REG_W-1:0]  DEB_RELOAD_RST = 8'd70;

	localparam int AMP_RST    = 1023;
	localparam int PERIOD_RST = 100;
	localparam int STEP_RST   = 10;

	// key bits
	localparam int KEY_AMP_UP = 0;
	localparam int KEY_AMP_DN = 1;
	localparam int KEY_PER_UP = 2;
	localparam int KEY_PER_DN = 3;

	typedef struct packed {
		logic tick;
		logic div_run;
	} cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_last;
	} sts_t;

endpackage

// File: rtl/sawtooth_generator_with_key_control_top.sv
// sawtooth_generator_with_key_control_top: top level of the key-controlled sawtooth generator
// joins the controller and the datapath
// depends on sawgen_pkg, sawgen_ctrl, sawgen_dp
//
// usage
// - input channel in_valid/in_ready carries one timebase tick per transaction with the raw
//   four-key sample on keys
// - output channel out_valid/out_ready returns one result per tick: dac_sample, ramp_restart,
//   amplitude_now and period_now, held in an output register until taken
// - config port cfg_wr_en/cfg_index/cfg_data writes one of the six limit registers per write;
//   write only while the block is idle
// - the result is registered and is presented in the cycle after its tick is taken
// - throughput is one tick per cycle, except that a tick which applies a confirmed key press
//   starts the step division amplitude / period, a restoring divider that retires one
//   quotient bit per cycle, and no further tick is taken until that division has finished
// - a new tick is taken while the previous result is being handed over; while the receiver
//   stalls the result holds and no further tick is taken
// - reset loads the default limits, period 100, amplitude full scale, step 10, sample zero
module sawtooth_generator_with_key_control_top #(
	parameter int SAMPLE_BITS = 10,
	parameter int PERIOD_BITS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [sawgen_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sawgen_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [sawgen_pkg::KEY_W-1:0]      keys,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [SAMPLE_BITS-1:0]            dac_sample,
	output logic                              ramp_restart,
	output logic [SAMPLE_BITS-1:0]            amplitude_now,
	output logic [PERIOD_BITS-1:0]            period_now
);
	import sawgen_pkg::*;

	cmd_t cmd;
	sts_t sts;

	sawgen_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	sawgen_dp #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.PERIOD_BITS (PERIOD_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.keys          (keys),
		.cmd           (cmd),
		.sts           (sts),
		.dac_sample    (dac_sample),
		.ramp_restart  (ramp_restart),
		.amplitude_now (amplitude_now),
		.period_now    (period_now)
	);

endmodule

// File: rtl/sawgen_ctrl.sv
// sawgen_ctrl: controller of the sawtooth generator
// sequences tick transactions, step division and the output register handshake
// depends on sawgen_pkg
module sawgen_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  sawgen_pkg::sts_t  sts,
	output sawgen_pkg::cmd_t  cmd
);
	import sawgen_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_DIV  = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign in_ready    = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign out_valid   = out_valid_q;
	assign cmd.tick    = in_valid && in_ready;
	assign cmd.div_run = (state_q == ST_DIV);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.tick && sts.need_div) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (sts.div_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.tick) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_no_accept_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> !in_ready)
		else $error("input accepted during step division");

	a_result_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.tick))
		else $error("result appeared without a tick transaction");

	a_div_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && sts.div_last) |=> (state_q == ST_IDLE))
		else $error("division did not finish on its last step");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> out_valid_q)
		else $error("pending result dropped while receiver stalled");

endmodule

// File: rtl/sawgen_dp.sv
// sawgen_dp: datapath of the sawtooth generator
// ramp counter, sample, debounce, key limits, restoring step divider, config and result registers
// depends on sawgen_pkg
module sawgen_dp #(
	parameter int SAMPLE_BITS = 10,
	parameter int PERIOD_BITS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [sawgen_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sawgen_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [sawgen_pkg::KEY_W-1:0]        keys,
	input  sawgen_pkg::cmd_t                    cmd,
	output sawgen_pkg::sts_t                    sts,
	output logic [SAMPLE_BITS-1:0]              dac_sample,
	output logic                                ramp_restart,
	output logic [SAMPLE_BITS-1:0]              amplitude_now,
	output logic [PERIOD_BITS-1:0]              period_now
);
	import sawgen_pkg::*;

	localparam int AW  = ((SAMPLE_BITS > CFG_DATA_W) ? SAMPLE_BITS : CFG_DATA_W) + 1;
	localparam int PRW = (PERIOD_BITS > CFG_REG_W) ? PERIOD_BITS : CFG_REG_W;
	localparam int QW  = PRW + 1;
	localparam int CW  = $clog2(SAMPLE_BITS);
	localparam logic [SAMPLE_BITS-1:0] SMASK = {SAMPLE_BITS{1'b1}};

	// configuration registers
	logic [CFG_DATA_W-1:0] amp_max_q;
	logic [CFG_REG_W-1:0]  amp_step_q, per_min_q, per_max_q, per_step_q, deb_reload_q;

	// block state
	logic [PERIOD_BITS-1:0] ramp_cnt_q;
	logic [PRW-1:0]         period_q;
	logic [SAMPLE_BITS-1:0] amp_q, step_q, sample_q;
	logic [CFG_REG_W-1:0]   deb_cnt_q;
	logic                   phase_q;
	logic [KEY_W-1:0]       held_q;

	// divider
	logic [SAMPLE_BITS-1:0] dvd_q;
	logic [PRW-1:0]         dvs_q, rem_q;
	logic [CW-1:0]          cnt_q;

	// result register
	logic [SAMPLE_BITS-1:0] dac_q, ampo_q;
	logic [PERIOD_BITS-1:0] pero_q;
	logic                   restart_q;

	logic [SAMPLE_BITS:0]   s_sum;
	logic [SAMPLE_BITS-1:0] sample_n;
	logic [PERIOD_BITS-1:0] ramp_cnt_n;
	logic                   ramp_zero, deb_fire, apply;
	logic [AW-1:0]          amp_w, ast_w, amx_w, amx_nz, amx_eff, a_up, a_up_c, a_dn, a_sel;
	logic [QW-1:0]          per_w, pst_w, lo_w, pmx_w, hi_w, p_up, p_up_c, p_dn, p_sel;
	logic [PERIOD_BITS-1:0] p_mask, p_fix;
	logic [SAMPLE_BITS-1:0] amp_new, amp_next;
	logic [PRW-1:0]         period_new, period_next;
	logic [QW-1:0]          trial;
	logic                   q_bit;
	logic [PRW-1:0]         rem_n;
	logic [SAMPLE_BITS-1:0] dvd_n;

	// ramp
	always_comb begin
		ramp_zero = (ramp_cnt_q == '0);
		s_sum     = {1'b0, sample_q} + {1'b0, step_q};
		if (ramp_zero) begin
			sample_n   = '0;
			ramp_cnt_n = period_q[PERIOD_BITS-1:0];
		end else begin
			sample_n   = s_sum[SAMPLE_BITS] ? SMASK : s_sum[SAMPLE_BITS-1:0];
			ramp_cnt_n = ramp_cnt_q - PERIOD_BITS'(1);
		end
	end

	// debounce and key limits
	always_comb begin
		deb_fire = (deb_cnt_q == '0);
		apply    = deb_fire && phase_q && (keys == held_q);

		amp_w   = AW'(amp_q);
		ast_w   = AW'(amp_step_q);
		amx_w   = AW'(amp_max_q);
		amx_nz  = (amx_w == '0) ? AW'(1) : amx_w;
		amx_eff = (amx_nz > AW'(SMASK)) ? AW'(SMASK) : amx_nz;
		a_up    = amp_w + ast_w;
		a_up_c  = (a_up > amx_eff) ? amx_eff : a_up;
		a_dn    = (amp_w > ast_w + AW'(1)) ? amp_w - ast_w : AW'(1);
		if (held_q[KEY_AMP_UP]) begin
			a_sel = a_up_c;
		end else if (held_q[KEY_AMP_DN]) begin
			a_sel = a_dn;
		end else begin
			a_sel = amp_w;
		end
		amp_new = a_sel[SAMPLE_BITS-1:0];

		per_w  = QW'(period_q);
		pst_w  = QW'(per_step_q);
		lo_w   = (per_min_q == '0) ? QW'(1) : QW'(per_min_q);
		pmx_w  = QW'(per_max_q);
		hi_w   = (pmx_w < lo_w) ? lo_w : pmx_w;
		p_up   = per_w + pst_w;
		p_up_c = (p_up > hi_w) ? hi_w : p_up;
		p_dn   = (per_w >= lo_w + pst_w) ? per_w - pst_w : lo_w;
		if (held_q[KEY_PER_UP]) begin
			p_sel = p_up_c;
		end else if (held_q[KEY_PER_DN]) begin
			p_sel = p_dn;
		end else begin
			p_sel = per_w;
		end
		p_mask     = p_sel[PERIOD_BITS-1:0];
		p_fix      = (p_mask == '0) ? PERIOD_BITS'(1) : p_mask;
		period_new = PRW'(p_fix);

		amp_next    = apply ? amp_new : amp_q;
		period_next = apply ? period_new : period_q;
	end

	assign sts.need_div = apply && (held_q != '0);
	assign sts.div_last = cmd.div_run && (cnt_q == CW'(SAMPLE_BITS - 1));

	// one restoring step per cycle
	always_comb begin
		trial = {rem_q, dvd_q[SAMPLE_BITS-1]};
		q_bit = (trial >= {1'b0, dvs_q});
		rem_n = q_bit ? PRW'(trial - {1'b0, dvs_q}) : trial[PRW-1:0];
		dvd_n = {dvd_q[SAMPLE_BITS-2:0], q_bit};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_max_q    <= AMP_MAX_RST;
			amp_step_q   <= AMP_STEP_RST;
			per_min_q    <= PER_MIN_RST;
			per_max_q    <= PER_MAX_RST;
			per_step_q   <= PER_STEP_RST;
			deb_reload_q <= DEB_RELOAD_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_AMP_MAX:    amp_max_q    <= cfg_data;
				REG_AMP_STEP:   amp_step_q   <= cfg_data[CFG_REG_W-1:0];
				REG_PER_MIN:    per_min_q    <= cfg_data[CFG_REG_W-1:0];
				REG_PER_MAX:    per_max_q    <= cfg_data[CFG_REG_W-1:0];
				REG_PER_STEP:   per_step_q   <= cfg_data[CFG_REG_W-1:0];
				REG_DEB_RELOAD: deb_reload_q <= cfg_data[CFG_REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_cnt_q <= PERIOD_BITS'(PERIOD_RST);
			period_q   <= PRW'(PERIOD_RST);
			amp_q      <= SAMPLE_BITS'(AMP_RST);
			step_q     <= SAMPLE_BITS'(STEP_RST);
			sample_q   <= '0;
			deb_cnt_q  <= DEB_RELOAD_RST;
			phase_q    <= 1'b0;
			held_q     <= '0;
			cnt_q      <= '0;
		end else begin
			if (cmd.tick) begin
				ramp_cnt_q <= ramp_cnt_n;
				sample_q   <= sample_n;
				amp_q      <= amp_next;
				period_q   <= period_next;
				cnt_q      <= '0;
				if (deb_fire) begin
					deb_cnt_q <= deb_reload_q;
					phase_q   <= !phase_q;
					if (!phase_q) begin
						held_q <= keys;
					end
				end else begin
					deb_cnt_q <= deb_cnt_q - CFG_REG_W'(1);
				end
			end else if (cmd.div_run) begin
				cnt_q <= cnt_q + CW'(1);
				if (sts.div_last) begin
					step_q <= dvd_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tick) begin
			dac_q     <= sample_n;
			restart_q <= ramp_zero;
			ampo_q    <= amp_next;
			pero_q    <= period_next[PERIOD_BITS-1:0];
			dvd_q     <= amp_new;
			dvs_q     <= period_new;
			rem_q     <= '0;
		end else if (cmd.div_run) begin
			dvd_q <= dvd_n;
			rem_q <= rem_n;
		end
	end

	assign dac_sample    = dac_q;
	assign ramp_restart  = restart_q;
	assign amplitude_now = ampo_q;
	assign period_now    = pero_q;

endmodule

// File: verif/tb_top.sv
// tb_top: self-checking testbench for sawtooth_generator_with_key_control_top
// keeps its own model of ramp, debounce and key limits and checks every result transaction
// depends on sawgen_pkg and the rtl top level
`timescale 1ns / 1ps

module tb_top;
	import sawgen_pkg::*;

	localparam int SAMPLE_BITS = 10;
	localparam int PERIOD_BITS = 8;
	localparam int FULL_SCALE  = (1 << SAMPLE_BITS) - 1;

	localparam logic [CFG_IDX_W-1:0] SPARE_IDX_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] SPARE_IDX_B = 3'd7;

	localparam logic [KEY_W-1:0] K_AU = 4'(1 << KEY_AMP_UP);
	localparam logic [KEY_W-1:0] K_AD = 4'(1 << KEY_AMP_DN);
	localparam logic [KEY_W-1:0] K_PU = 4'(1 << KEY_PER_UP);
	localparam logic [KEY_W-1:0] K_PD = 4'(1 << KEY_PER_DN);
	localparam logic [KEY_W-1:0] K_NONE = '0;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] smp;
		logic                   restart;
		logic [SAMPLE_BITS-1:0] amp;
		logic [PERIOD_BITS-1:0] per;
	} ramp_out_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [KEY_W-1:0]      keys = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [SAMPLE_BITS-1:0] dac_sample;
	logic                   ramp_restart;
	logic [SAMPLE_BITS-1:0] amplitude_now;
	logic [PERIOD_BITS-1:0] period_now;

	sawtooth_generator_with_key_control_top #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.PERIOD_BITS(PERIOD_BITS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.keys         (keys),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.dac_sample   (dac_sample),
		.ramp_restart (ramp_restart),
		.amplitude_now(amplitude_now),
		.period_now   (period_now)
	);

	always #4 clk = ~clk;

	// limit registers as seen by the model
	logic [CFG_DATA_W-1:0] c_amp_max;
	logic [CFG_REG_W-1:0]  c_amp_step, c_per_min, c_per_max, c_per_step, c_deb_reload;

	// model state
	logic [PERIOD_BITS-1:0] ramp_cnt, ramp_per;
	logic [SAMPLE_BITS-1:0] amp, step, smp;
	logic [7:0]             deb_cnt;
	logic                   deb_phase;
	logic [KEY_W-1:0]       held;

	logic [KEY_W-1:0] tick_keys_q[$];
	ramp_out_t        ramp_out_q[$];

	int  errors = 0;
	int  results_seen = 0;
	bit  in_took = 1'b0;
	bit  quiet = 1'b0;
	int  tx_gap = 0, rx_gap = 0, hold_left = 0;
	bit  tx_calm = 1'b0, rx_calm = 1'b0, held_off = 1'b0;

	function automatic void press_keys(logic [KEY_W-1:0] k);
		int amax, lo, hi, a, p, st, ps;
		amax = (c_amp_max == 0) ? 1 : int'(c_amp_max);
		lo   = (c_per_min == 0) ? 1 : int'(c_per_min);
		hi   = (int'(c_per_max) < lo) ? lo : int'(c_per_max);
		st   = int'(c_amp_step);
		ps   = int'(c_per_step);
		a    = int'(amp);
		p    = int'(ramp_per);
		if (k[KEY_AMP_UP]) begin
			a = (a + st > amax) ? amax : a + st;
		end else if (k[KEY_AMP_DN]) begin
			a = (a > st + 1) ? a - st : 1;
		end
		if (k[KEY_PER_UP]) begin
			p = (p + ps > hi) ? hi : p + ps;
		end else if (k[KEY_PER_DN]) begin
			p = (p >= lo + ps) ? p - ps : lo;
		end
		p = p & ((1 << PERIOD_BITS) - 1);
		if (p == 0)
			p = 1;
		amp      = SAMPLE_BITS'(a);
		ramp_per = PERIOD_BITS'(p);
		if (k != 0)
			step = SAMPLE_BITS'(a / p);
	endfunction

	function automatic ramp_out_t advance_ramp(logic [KEY_W-1:0] k);
		ramp_out_t r;
		int        s;
		r.restart = 1'b0;
		if (ramp_cnt != 0) begin
			s        = int'(smp) + int'(step);
			ramp_cnt = ramp_cnt - PERIOD_BITS'(1);
			smp      = (s > FULL_SCALE) ? SAMPLE_BITS'(FULL_SCALE) : SAMPLE_BITS'(s);
		end else begin
			ramp_cnt  = ramp_per;
			smp       = '0;
			r.restart = 1'b1;
		end
		if (deb_cnt != 0) begin
			deb_cnt = deb_cnt - 8'd1;
		end else begin
			deb_cnt = c_deb_reload;
			if (!deb_phase) begin
				held      = k;
				deb_phase = 1'b1;
			end else begin
				if (k == held)
					press_keys(held);
				deb_phase = 1'b0;
			end
		end
		r.smp = smp;
		r.amp = amp;
		r.per = ramp_per;
		return r;
	endfunction

	// input side: capture accepted ticks, check result transactions
	always @(posedge clk) begin
		ramp_out_t got, want;
		in_took = arst_n && in_valid && in_ready;
		if (in_took)
			ramp_out_q.push_back(advance_ramp(keys));
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			got = '{dac_sample, ramp_restart, amplitude_now, period_now};
			if (ramp_out_q.size() == 0) begin
				$error("result transaction with nothing expected");
				errors++;
			end else begin
				want = ramp_out_q.pop_front();
				if (got.smp !== want.smp) begin
					$error("dac_sample expected %0d got %0d", want.smp, got.smp);
					errors++;
				end
				if (got.restart !== want.restart) begin
					$error("ramp_restart expected %0d got %0d", want.restart, got.restart);
					errors++;
				end
				if (got.amp !== want.amp) begin
					$error("amplitude_now expected %0d got %0d", want.amp, got.amp);
					errors++;
				end
				if (got.per !== want.per) begin
					$error("period_now expected %0d got %0d", want.per, got.per);
					errors++;
				end
			end
		end
	end

	// tick driver
	always @(negedge clk) begin
		if ($urandom_range(0, 63) == 0)
			tx_calm = !tx_calm;
		if (arst_n && (!in_valid || in_took)) begin
			if (tx_gap > 0) begin
				tx_gap--;
				in_valid <= 1'b0;
			end else if (tick_keys_q.size() > 0) begin
				in_valid <= 1'b1;
				keys     <= tick_keys_q.pop_front();
				if (!quiet && !tx_calm && $urandom_range(0, 3) == 0)
					tx_gap = $urandom_range(1, 9);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result receiver
	always @(negedge clk) begin
		if ($urandom_range(0, 63) == 0)
			rx_calm = !rx_calm;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (!held_off && results_seen >= 300 && tick_keys_q.size() > 40) begin
			// long back-pressure so the input side stalls
			held_off = 1'b1;
			hold_left = 119;
			out_ready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if (!quiet && !rx_calm && $urandom_range(0, 4) == 0)
				rx_gap = $urandom_range(1, 9);
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data  = d;
		case (idx)
			REG_AMP_MAX:    c_amp_max    = d;
			REG_AMP_STEP:   c_amp_step   = d[CFG_REG_W-1:0];
			REG_PER_MIN:    c_per_min    = d[CFG_REG_W-1:0];
			REG_PER_MAX:    c_per_max    = d[CFG_REG_W-1:0];
			REG_PER_STEP:   c_per_step   = d[CFG_REG_W-1:0];
			REG_DEB_RELOAD: c_deb_reload = d[CFG_REG_W-1:0];
			default: ;
		endcase
	endtask

	task automatic load_limits(int am, int as, int pmin, int pmax, int pstep, int deb);
		write_reg($urandom_range(0, 1) ? SPARE_IDX_A : SPARE_IDX_B, CFG_DATA_W'($urandom));
		write_reg(REG_AMP_MAX, CFG_DATA_W'(am));
		write_reg(REG_AMP_STEP, {2'($urandom), 8'(as)});
		write_reg(REG_PER_MIN, {2'($urandom), 8'(pmin)});
		write_reg(REG_PER_MAX, {2'($urandom), 8'(pmax)});
		write_reg(REG_PER_STEP, {2'($urandom), 8'(pstep)});
		write_reg(REG_DEB_RELOAD, {2'($urandom), 8'(deb)});
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	task automatic push_run(logic [KEY_W-1:0] k, int n);
		repeat (n) tick_keys_q.push_back(k);
	endtask

	// mostly keys held long enough to pass the debounce, some noise
	task automatic queue_keys(int n);
		int               left, len, r;
		logic [KEY_W-1:0] k;
		left = n;
		r    = int'(c_deb_reload);
		while (left > 0) begin
			if ($urandom_range(0, 4) != 0) begin
				if ($urandom_range(0, 1))
					k = 4'(1 << $urandom_range(KEY_AMP_UP, KEY_PER_DN));
				else
					k = 4'($urandom);
				len = (r + 1) * $urandom_range(2, 4) + $urandom_range(0, r);
				if (len > left)
					len = left;
				push_run(k, len);
			end else begin
				len = $urandom_range(1, 6);
				if (len > left)
					len = left;
				repeat (len) tick_keys_q.push_back(4'($urandom));
			end
			left -= len;
		end
	endtask

	task automatic wait_drained();
		while (tick_keys_q.size() != 0 || in_valid || ramp_out_q.size() != 0)
			@(posedge clk);
		repeat (SAMPLE_BITS + 8) @(posedge clk);
	endtask

	initial begin
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		arst_n    = 1'b0;

		c_amp_max    = AMP_MAX_RST;
		c_amp_step   = AMP_STEP_RST;
		c_per_min    = PER_MIN_RST;
		c_per_max    = PER_MAX_RST;
		c_per_step   = PER_STEP_RST;
		c_deb_reload = DEB_RELOAD_RST;
		ramp_cnt     = PERIOD_BITS'(PERIOD_RST);
		ramp_per     = PERIOD_BITS'(PERIOD_RST);
		amp          = SAMPLE_BITS'(AMP_RST);
		step         = SAMPLE_BITS'(STEP_RST);
		smp          = '0;
		deb_cnt      = DEB_RELOAD_RST;
		deb_phase    = 1'b0;
		held         = '0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// default limits
		queue_keys(140);
		wait_drained();

		// short debounce reload; the count left over from before still runs down first
		load_limits(1023, 255, 1, 255, 255, 3);
		queue_keys(100);
		wait_drained();

		// directed: debounce on every tick, each three-tick run is one press
		load_limits(1023, 255, 0, 255, 255, 0);
		push_run(K_NONE, 4);
		push_run(K_AU | K_PU, 3);
		push_run(K_AD | K_PD, 3);
		push_run(K_AD, 3);
		push_run(K_AU | K_AD, 3);
		push_run(K_PU | K_PD, 3);
		push_run(K_AU, 1);
		push_run(K_AD, 1);
		push_run(K_AU, 1);
		push_run(K_AD, 1);
		push_run(K_PD, 2);
		wait_drained();

		// all limits zero
		load_limits(0, 0, 0, 0, 0, 0);
		queue_keys(120);
		wait_drained();

		// amplitude and period limits at full scale, short debounce
		load_limits(1023, 255, 255, 255, 255, 1);
		queue_keys(120);
		wait_drained();

		// period max below period min
		load_limits(20, 7, 50, 10, 3, 2);
		queue_keys(100);
		wait_drained();

		// wide swings, sample saturation
		load_limits(1023, 255, 1, 255, 255, 0);
		queue_keys(100);
		wait_drained();

		// period above the new high bound
		load_limits(300, 30, 5, 40, 15, 4);
		queue_keys(120);
		wait_drained();

		// longest debounce
		load_limits(1023, 100, 1, 255, 50, 255);
		queue_keys(280);
		wait_drained();

		repeat (3) begin
			load_limits($urandom_range(0, 1023), $urandom_range(0, 255), $urandom_range(0, 60),
				$urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 7));
			queue_keys(80);
			wait_drained();
		end

		// closing stretch with no idling
		quiet = 1'b1;
		load_limits(1023, 10, 1, 200, 10, 2);
		queue_keys(100);
		wait_drained();

		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
